/* src/mdaa_pkg.sv */
// Shared types, constants and register codes for the array address generator.
package mdaa_pkg;

    // Number of dimensions the bound stores can hold.
    localparam int MAX_DIMS = 8;

    // Width of a store index and of the per-query dimension counter.
    localparam int DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int CNT_W = $clog2(MAX_DIMS + 1);

    // Command queue between the front and the back.
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Configuration port geometry.
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] CFG_BASE_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_ELEMENT_SIZE = 2'd1;
    localparam logic [1:0] CFG_NUM_DIMS     = 2'd2;

    // Request type codes.
    localparam logic REQ_BOUND = 1'b0;
    localparam logic REQ_INDEX = 1'b1;

    // One input transaction.
    typedef struct packed {
        logic               req_type;
        logic [2:0]         dim_select;
        logic signed [15:0] lower_bound;
        logic signed [15:0] upper_bound;
        logic signed [15:0] index_value;
        logic               last_index;
    } req_t;

    // One output transaction.
    typedef struct packed {
        logic signed [63:0] address;
        logic               count_error;
        logic               overflow;
    } rsp_t;

    // Operation carried from the front to the back.
    typedef enum logic {
        OP_BOUND,
        OP_INDEX
    } op_t;

    // Queue entry: a classified item.
    typedef struct packed {
        op_t                op;
        logic [DIM_W-1:0]   dim;
        logic signed [15:0] lower_bound;
        logic signed [15:0] upper_bound;
        logic signed [15:0] index_value;
        logic               accumulate;
        logic               last;
        logic               count_error;
    } cmd_t;

endpackage

/* src/multi_dim_array_address.sv */
// Top level of the row-major array address generator with its register port.
//
// Bound transactions load one dimension's lower bound and extent; index
// transactions arrive outermost first, and the one marked last yields
// base_address + (row-major offset) * element_size, or a count error with
// address all ones when the number of indexes differs from num_dims. The
// front end takes one transaction per cycle until its two-entry queue is
// full. The back end works one queue entry at a time through a single
// 33x18 multiplier and an 82-bit adder: a bound item is stored as it is
// popped, an index item takes two multiplier passes over the 32-bit halves
// of the accumulator, a product sum and the offset add, and the index that
// closes a valid query repeats them for the element-size scaling before the
// emit state loads the result register. Signed 64-bit overflow anywhere in
// a query sets the overflow flag while the address keeps its wrapped value.
module multi_dim_array_address (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  mdaa_pkg::req_t                req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output mdaa_pkg::rsp_t                rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mdaa_pkg::ADDR_W-1:0]   paddr,
    input  logic [mdaa_pkg::DATA_W-1:0]   pwdata,
    output logic [mdaa_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import mdaa_pkg::*;

    logic [31:0] base_address_reg;
    logic [15:0] element_size_reg;
    logic [3:0]  num_dims_reg;
    logic        cfg_write;

    logic        push;
    cmd_t        push_cmd;
    logic        full;
    logic        pop;
    logic        q_valid;
    cmd_t        q_head;

    // Register port: every access completes in its access cycle.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_address_reg <= '0;
            element_size_reg <= 16'd1;
            num_dims_reg     <= 4'd1;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                CFG_BASE_ADDRESS: base_address_reg <= pwdata;
                CFG_ELEMENT_SIZE: element_size_reg <= pwdata[15:0];
                CFG_NUM_DIMS:     num_dims_reg     <= pwdata[3:0];
                default:          ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (paddr[3:2])
            CFG_BASE_ADDRESS: prdata = base_address_reg;
            CFG_ELEMENT_SIZE: prdata = {16'b0, element_size_reg};
            CFG_NUM_DIMS:     prdata = {28'b0, num_dims_reg};
            default:          prdata = '0;
        endcase
    end

    mdaa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .num_dims  (num_dims_reg),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (full)
    );

    mdaa_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .valid    (q_valid),
        .head     (q_head)
    );

    mdaa_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (pop),
        .base_address (base_address_reg),
        .element_size (element_size_reg),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .rsp          (rsp)
    );

endmodule

/* src/mdaa_front.sv */
// Front end: accepts transactions, tracks the index count and classifies items.
module mdaa_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  mdaa_pkg::req_t       req,
    input  logic [3:0]           num_dims,
    output logic                 push,
    output mdaa_pkg::cmd_t       push_cmd,
    input  logic                 full
);
    import mdaa_pkg::*;

    logic [CNT_W-1:0] dims_seen_reg;
    logic [CNT_W-1:0] dims_seen_next;
    logic             excess_reg;
    logic             excess_next;
    logic             accept;
    logic             can_acc;
    logic             dim_ok;
    logic             cerr;

    // Stall while the queue has no room.
    assign req_stall = full;
    assign accept    = req_valid && !full;

    // Classify the item against the running query count.
    always_comb
    begin
        dim_ok         = 32'(req.dim_select) < MAX_DIMS;
        can_acc        = (32'(dims_seen_reg) < 32'(num_dims)) &&
                         (32'(dims_seen_reg) < MAX_DIMS);
        dims_seen_next = can_acc ? dims_seen_reg + CNT_W'(1) : dims_seen_reg;
        excess_next    = excess_reg || !can_acc;
        cerr           = excess_next || (32'(dims_seen_next) != 32'(num_dims)) ||
                         (32'(num_dims) > MAX_DIMS);
    end

    // Build the queue entry; surplus index items that end nothing are dropped.
    always_comb
    begin
        push_cmd.lower_bound = req.lower_bound;
        push_cmd.upper_bound = req.upper_bound;
        push_cmd.index_value = req.index_value;
        push_cmd.last        = req.last_index;
        push_cmd.count_error = cerr;
        if (req.req_type == REQ_BOUND)
        begin
            push_cmd.op         = OP_BOUND;
            push_cmd.dim        = DIM_W'(req.dim_select);
            push_cmd.accumulate = 1'b0;
            push                = accept && dim_ok;
        end
        else
        begin
            push_cmd.op         = OP_INDEX;
            push_cmd.dim        = DIM_W'(dims_seen_reg);
            push_cmd.accumulate = can_acc;
            push                = accept && (can_acc || req.last_index);
        end
    end

    // Query count state; a last index starts a fresh query.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_seen_reg <= '0;
            excess_reg    <= 1'b0;
        end
        else if (accept && req.req_type == REQ_INDEX)
        begin
            if (req.last_index)
            begin
                dims_seen_reg <= '0;
                excess_reg    <= 1'b0;
            end
            else
            begin
                dims_seen_reg <= dims_seen_next;
                excess_reg    <= excess_next;
            end
        end
    end

endmodule

/* src/mdaa_queue.sv */
// Short command queue between the front end and the arithmetic back end.
module mdaa_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mdaa_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output mdaa_pkg::cmd_t head
);
    import mdaa_pkg::*;

    cmd_t            mem [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_CW-1:0] count_reg;

    assign full  = (32'(count_reg) == Q_DEPTH);
    assign valid = (count_reg != '0);
    assign head  = mem[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == Q_DEPTH - 1) ? '0 : wr_ptr_reg + Q_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == Q_DEPTH - 1) ? '0 : rd_ptr_reg + Q_AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + Q_CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - Q_CW'(1);
            end
        end
    end

endmodule

/* src/mdaa_back.sv */
// Back end: bound stores, shared multiply-add unit and the result register.
module mdaa_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  mdaa_pkg::cmd_t q_head,
    output logic           q_pop,
    input  logic [31:0]    base_address,
    input  logic [15:0]    element_size,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output mdaa_pkg::rsp_t rsp
);
    import mdaa_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM,
        ST_ADD,
        ST_EMIT
    } state_t;

    state_t             state_reg;
    logic signed [15:0] lower_mem  [MAX_DIMS];
    logic signed [17:0] extent_mem [MAX_DIMS];

    logic [63:0]        acc_reg;
    logic               ov_seen_reg;
    logic signed [17:0] m_reg;
    logic signed [33:0] addend_reg;
    logic signed [50:0] plo_reg;
    logic signed [49:0] phi_reg;
    logic [81:0]        prod_reg;
    logic               final_reg;
    logic               last_reg;
    logic               cerr_reg;
    logic               rsp_valid_reg;
    rsp_t               rsp_reg;

    logic               mul_ov;
    logic [64:0]        sum;
    logic               add_ov;
    logic               ov_all;

    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Overflow checks: the exact product must fit 64 signed bits, and so must the sum.
    always_comb
    begin
        mul_ov = !((&prod_reg[81:63]) || !(|prod_reg[81:63]));
        sum    = {prod_reg[63], prod_reg[63:0]} + {{31{addend_reg[33]}}, addend_reg};
        add_ov = sum[64] != sum[63];
        ov_all = ov_seen_reg || mul_ov || add_ov;
    end

    // Bound stores, written by bound items in queue order.
    always_ff @(posedge clk)
    begin
        if (q_pop && q_head.op == OP_BOUND)
        begin
            lower_mem[q_head.dim]  <= q_head.lower_bound;
            extent_mem[q_head.dim] <= 18'(q_head.upper_bound) - 18'(q_head.lower_bound)
                                      + 18'sd1;
        end
    end

    // Sequencer: acc*m over two 32-bit halves, their sum, then the add, then the result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            ov_seen_reg   <= 1'b0;
            m_reg         <= '0;
            addend_reg    <= '0;
            plo_reg       <= '0;
            phi_reg       <= '0;
            prod_reg      <= '0;
            final_reg     <= 1'b0;
            last_reg      <= 1'b0;
            cerr_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            // The result register empties here unless the emit state refills it.
            if (rsp_valid_reg && !rsp_stall && state_reg != ST_EMIT)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid && q_head.op == OP_INDEX)
                    begin
                        last_reg  <= q_head.last;
                        cerr_reg  <= q_head.count_error;
                        final_reg <= 1'b0;
                        if (q_head.accumulate)
                        begin
                            m_reg      <= extent_mem[q_head.dim];
                            addend_reg <= 34'(q_head.index_value) -
                                          34'(lower_mem[q_head.dim]);
                            state_reg  <= ST_MUL_LO;
                        end
                        else
                        begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_MUL_LO:
                begin
                    plo_reg   <= $signed({1'b0, acc_reg[31:0]}) * m_reg;
                    state_reg <= ST_MUL_HI;
                end
                ST_MUL_HI:
                begin
                    phi_reg   <= $signed(acc_reg[63:32]) * m_reg;
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    prod_reg  <= {phi_reg, 32'b0} + {{31{plo_reg[50]}}, plo_reg};
                    state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    acc_reg     <= sum[63:0];
                    ov_seen_reg <= ov_all;
                    if (final_reg || (last_reg && cerr_reg))
                    begin
                        state_reg <= ST_EMIT;
                    end
                    else if (last_reg)
                    begin
                        // Valid query: scale by the element size and add the base.
                        final_reg  <= 1'b1;
                        m_reg      <= {2'b00, element_size};
                        addend_reg <= {2'b00, base_address};
                        state_reg  <= ST_MUL_LO;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_EMIT:
                begin
                    if (!rsp_valid_reg || !rsp_stall)
                    begin
                        rsp_valid_reg       <= 1'b1;
                        rsp_reg.address     <= cerr_reg ? '1 : acc_reg;
                        rsp_reg.count_error <= cerr_reg;
                        rsp_reg.overflow    <= cerr_reg ? 1'b0 : ov_seen_reg;
                        acc_reg             <= '0;
                        ov_seen_reg         <= 1'b0;
                        state_reg           <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* src/mdaa_checker.sv */
// Port-level checks for the array address generator, bound to its top level.
module mdaa_port_asserts (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_stall,
    input mdaa_pkg::req_t                req,
    input logic                          rsp_valid,
    input logic                          rsp_stall,
    input mdaa_pkg::rsp_t                rsp,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [mdaa_pkg::ADDR_W-1:0]   paddr,
    input logic [mdaa_pkg::DATA_W-1:0]   pwdata,
    input logic [mdaa_pkg::DATA_W-1:0]   prdata,
    input logic                          pready
);
    import mdaa_pkg::*;

    // A stalled request transaction stays offered with the same payload.
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(req))
        else $error("request changed while stalled");

    // A stalled result transaction keeps its payload.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // A count error carries the all-ones address and no overflow.
    a_cerr_form: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.count_error |-> !rsp.overflow && (rsp.address == '1))
        else $error("malformed count error result");

    // The register port never inserts wait states.
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable |-> pready)
        else $error("register access not ready");

    // A base address write is visible on read-back in the next cycle while paddr still selects it.
    a_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && (paddr[3:2] == CFG_BASE_ADDRESS) |=>
        (paddr != $past(paddr)) || (prdata == $past(pwdata)))
        else $error("base address read-back mismatch");

endmodule

bind multi_dim_array_address mdaa_port_asserts u_port_asserts (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
);
